[sv/pht_pkg.sv]
// Shared types, constants and helper functions for the prefix handler table.
// Used by pht_front, pht_back and prefix_handler_table_top; depends on nothing.
`default_nettype none

package pht_pkg;

    localparam int HANDLE_W = 8;
    localparam int KEY_W    = 128;
    localparam int HALF_W   = 64;
    localparam int LEN_W    = 8;
    localparam int CNT_W    = 8;
    localparam int SEG_W    = 32;
    localparam int SEG_N    = KEY_W / SEG_W;
    localparam int SEG_LZ_W = 6;
    localparam int WORD_W   = HANDLE_W + KEY_W + LEN_W;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;

    localparam logic [SEG_LZ_W-1:0] SEG_FULL = 6'd32;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_LOOKUP     = 2'd2,
        CMD_UNUSED     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd                op;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    data;
        logic [LEN_W-1:0]    len;
    } t_job;

    typedef struct packed {
        logic vld;
        t_job job;
    } t_req;

    function automatic logic [SEG_LZ_W-1:0] lzc32(input logic [SEG_W-1:0] x);
        logic [SEG_LZ_W-1:0] n;
        n = SEG_FULL;
        for (int i = 0; i < SEG_W; i++) begin
            if (x[i]) begin
                n = SEG_LZ_W'(SEG_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[sv/pht_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used by pht_back for the entry store; depends on nothing.
`default_nettype none

module pht_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/pht_front.sv]
// Front end: accepts commands, classifies them into jobs and queues them.
// Depends on pht_pkg; feeds pht_back through a two-entry queue.
`default_nettype none

module pht_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [1:0]                   i_command,
    input  wire logic [pht_pkg::HANDLE_W-1:0] i_handle,
    input  wire logic [pht_pkg::HALF_W-1:0]   i_prefix_hi,
    input  wire logic [pht_pkg::HALF_W-1:0]   i_prefix_lo,
    input  wire logic [pht_pkg::LEN_W-1:0]    i_prefix_bits,
    input  wire logic [pht_pkg::HALF_W-1:0]   i_key_hi,
    input  wire logic [pht_pkg::HALF_W-1:0]   i_key_lo,
    output logic                              o_busy,
    output pht_pkg::t_req                     o_req,
    input  wire logic                         i_pop
);

    pht_pkg::t_job                     n_job;
    pht_pkg::t_job                     r_q [pht_pkg::QDEPTH];
    logic [pht_pkg::QPTR_W-1:0]        r_wptr;
    logic [pht_pkg::QPTR_W-1:0]        r_rptr;
    logic [pht_pkg::QCNT_W-1:0]        r_cnt;
    logic                              push;
    logic                              pop;

    always_comb begin
        n_job.op     = pht_pkg::t_cmd'(i_command);
        n_job.handle = i_handle;
        n_job.len    = i_prefix_bits;
        if (n_job.op == pht_pkg::CMD_LOOKUP) begin
            n_job.data = {i_key_hi, i_key_lo};
        end else begin
            n_job.data = {i_prefix_hi, i_prefix_lo};
        end
    end

    assign o_busy = (r_cnt == pht_pkg::QCNT_W'(pht_pkg::QDEPTH));
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_cnt != '0);

    assign o_req.vld = (r_cnt != '0);
    assign o_req.job = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == pht_pkg::QPTR_W'(pht_pkg::QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == pht_pkg::QPTR_W'(pht_pkg::QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_job;
        end
    end

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

[sv/pht_back.sv]
// Back end: walks the entry store one entry a cycle through a short pipeline
// and carries out register, unregister and lookup. Depends on pht_pkg, pht_ram.
`default_nettype none

module pht_back #(
    parameter int ENTRIES = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pht_pkg::t_req                i_req,
    output logic                              o_pop,
    input  wire logic                         i_default_pass,
    output logic                              o_strobe,
    output logic [1:0]                        o_status,
    output logic                              o_hit,
    output logic [2:0]                        o_entry_index,
    output logic [pht_pkg::HANDLE_W-1:0]      o_matched_handle,
    output logic [pht_pkg::CNT_W-1:0]         o_common_bits,
    output logic                              o_verdict_default
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    pht_pkg::t_job                       r_job;
    logic [ENTRIES-1:0]                  r_valid;
    logic [IDX_W-1:0]                    r_rd_ctr;
    logic                                r_iss;
    logic                                r_s1_vld;
    logic                                r_s1_last;
    logic [IDX_W-1:0]                    r_s1_idx;
    logic                                r_s2_vld;
    logic                                r_s2_last;
    logic [IDX_W-1:0]                    r_s2_idx;
    logic [pht_pkg::HANDLE_W-1:0]        r_s2_handle;
    logic [pht_pkg::LEN_W-1:0]           r_s2_len;
    logic [pht_pkg::SEG_LZ_W-1:0]        r_s2_seg [pht_pkg::SEG_N];
    logic                                r_found;
    logic [pht_pkg::CNT_W-1:0]           r_best;
    logic [IDX_W-1:0]                    r_idx;
    logic [pht_pkg::HANDLE_W-1:0]        r_mhandle;

    logic                                r_out_vld;
    logic [1:0]                          r_o_status;
    logic                                r_o_hit;
    logic [2:0]                          r_o_index;
    logic [pht_pkg::HANDLE_W-1:0]        r_o_handle;
    logic [pht_pkg::CNT_W-1:0]           r_o_common;
    logic                                r_o_verdict;

    logic [1:0]                          n_o_status;
    logic                                n_o_hit;
    logic [2:0]                          n_o_index;
    logic [pht_pkg::HANDLE_W-1:0]        n_o_handle;
    logic [pht_pkg::CNT_W-1:0]           n_o_common;

    logic                                ram_we;
    logic [pht_pkg::WORD_W-1:0]          ram_wdata;
    logic [pht_pkg::WORD_W-1:0]          ram_rdata;

    logic [pht_pkg::HANDLE_W-1:0]        s1_word_handle;
    logic [pht_pkg::KEY_W-1:0]           s1_word_prefix;
    logic [pht_pkg::LEN_W-1:0]           s1_word_len;
    logic [pht_pkg::KEY_W-1:0]           s1_diff;
    logic [pht_pkg::HANDLE_W-1:0]        s1_handle;
    logic [pht_pkg::SEG_LZ_W-1:0]        s1_seg [pht_pkg::SEG_N];

    logic [pht_pkg::CNT_W-1:0]           s2_cnt;
    logic                                s2_take;
    logic [IDX_W+2:0]                    idx_ext;

    pht_ram #(
        .WIDTH (pht_pkg::WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_ctr),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = (r_state == S_DONE) && r_found && (r_job.op == pht_pkg::CMD_REGISTER);
    assign ram_wdata = {r_job.handle, r_job.data, r_job.len};
    assign o_pop     = (r_state == S_IDLE) && i_req.vld;

    // Stage one: unpack the stored word and count leading equal bits per segment.
    always_comb begin
        s1_word_handle = ram_rdata[pht_pkg::WORD_W-1 -: pht_pkg::HANDLE_W];
        s1_word_prefix = ram_rdata[pht_pkg::LEN_W +: pht_pkg::KEY_W];
        s1_word_len    = ram_rdata[pht_pkg::LEN_W-1:0];
        s1_diff        = s1_word_prefix ^ r_job.data;
        s1_handle      = r_valid[r_s1_idx] ? s1_word_handle : '0;
        for (int k = 0; k < pht_pkg::SEG_N; k++) begin
            s1_seg[k] = pht_pkg::lzc32(s1_diff[pht_pkg::KEY_W-1-k*pht_pkg::SEG_W -: pht_pkg::SEG_W]);
        end
    end

    // Stage two: merge segment counts and decide whether this entry wins.
    always_comb begin
        if (r_s2_seg[0] != pht_pkg::SEG_FULL) begin
            s2_cnt = {2'b00, r_s2_seg[0]};
        end else if (r_s2_seg[1] != pht_pkg::SEG_FULL) begin
            s2_cnt = 8'd32 + {2'b00, r_s2_seg[1]};
        end else if (r_s2_seg[2] != pht_pkg::SEG_FULL) begin
            s2_cnt = 8'd64 + {2'b00, r_s2_seg[2]};
        end else if (r_s2_seg[3] != pht_pkg::SEG_FULL) begin
            s2_cnt = 8'd96 + {2'b00, r_s2_seg[3]};
        end else begin
            s2_cnt = 8'd128;
        end

        s2_take = 1'b0;
        if (r_s2_vld) begin
            unique case (r_job.op)
                pht_pkg::CMD_REGISTER: begin
                    s2_take = !r_found && (r_s2_handle == '0);
                end
                pht_pkg::CMD_UNREGISTER: begin
                    s2_take = !r_found && (r_s2_handle == r_job.handle);
                end
                pht_pkg::CMD_LOOKUP: begin
                    s2_take = (r_s2_handle != '0) && (s2_cnt >= r_s2_len) && (s2_cnt > r_best);
                end
                pht_pkg::CMD_UNUSED: begin
                    s2_take = 1'b0;
                end
                default: begin
                    s2_take = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = i_req.vld ? S_SCAN : S_IDLE;
            S_SCAN:  n_state = (r_s2_vld && r_s2_last) ? S_DONE : S_SCAN;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign idx_ext = {3'b000, r_idx};

    always_comb begin
        n_o_status = pht_pkg::ST_OK;
        n_o_hit    = 1'b0;
        n_o_index  = '0;
        n_o_handle = '0;
        n_o_common = '0;
        unique case (r_job.op)
            pht_pkg::CMD_REGISTER: begin
                n_o_status = r_found ? pht_pkg::ST_OK : pht_pkg::ST_FULL;
                n_o_index  = r_found ? idx_ext[2:0] : 3'b000;
            end
            pht_pkg::CMD_UNREGISTER: begin
                n_o_status = r_found ? pht_pkg::ST_OK : pht_pkg::ST_NOT_FOUND;
                n_o_index  = r_found ? idx_ext[2:0] : 3'b000;
            end
            pht_pkg::CMD_LOOKUP: begin
                n_o_hit    = r_found;
                n_o_index  = r_found ? idx_ext[2:0] : 3'b000;
                n_o_handle = r_found ? r_mhandle : '0;
                n_o_common = r_found ? r_best : '0;
            end
            pht_pkg::CMD_UNUSED: begin
                n_o_status = pht_pkg::ST_OK;
            end
            default: begin
                n_o_status = pht_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_iss     <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= r_iss;
            r_s2_vld  <= r_s1_vld;
            r_out_vld <= (r_state == S_DONE);
            if ((r_state == S_IDLE) && i_req.vld) begin
                r_iss <= 1'b1;
            end else if (r_iss && (r_rd_ctr == LAST_IDX)) begin
                r_iss <= 1'b0;
            end
            if ((r_state == S_DONE) && r_found) begin
                if (r_job.op == pht_pkg::CMD_REGISTER) begin
                    r_valid[r_idx] <= (r_job.handle != '0);
                end else if (r_job.op == pht_pkg::CMD_UNREGISTER) begin
                    r_valid[r_idx] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_req.vld) begin
            r_job     <= i_req.job;
            r_rd_ctr  <= '0;
            r_found   <= 1'b0;
            r_best    <= '0;
            r_idx     <= '0;
            r_mhandle <= '0;
        end else begin
            if (r_iss) begin
                r_rd_ctr <= r_rd_ctr + 1'b1;
            end
            if (s2_take) begin
                r_found   <= 1'b1;
                r_idx     <= r_s2_idx;
                r_best    <= s2_cnt;
                r_mhandle <= r_s2_handle;
            end
        end

        r_s1_idx    <= r_rd_ctr;
        r_s1_last   <= (r_rd_ctr == LAST_IDX);
        r_s2_idx    <= r_s1_idx;
        r_s2_last   <= r_s1_last;
        r_s2_handle <= s1_handle;
        r_s2_len    <= s1_word_len;
        for (int k = 0; k < pht_pkg::SEG_N; k++) begin
            r_s2_seg[k] <= s1_seg[k];
        end

        if (r_state == S_DONE) begin
            r_o_status  <= n_o_status;
            r_o_hit     <= n_o_hit;
            r_o_index   <= n_o_index;
            r_o_handle  <= n_o_handle;
            r_o_common  <= n_o_common;
            r_o_verdict <= i_default_pass;
        end
    end

    assign o_strobe          = r_out_vld;
    assign o_status          = r_o_status;
    assign o_hit             = r_o_hit;
    assign o_entry_index     = r_o_index;
    assign o_matched_handle  = r_o_handle;
    assign o_common_bits     = r_o_common;
    assign o_verdict_default = r_o_verdict;

    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $past(r_state) == S_DONE)
        else $error("result strobe without a finished transaction");

    a_hit_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_o_hit) |-> (r_o_common != '0) && (r_o_handle != '0))
        else $error("lookup hit with zero common bits or empty handle");

    a_pipe_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> r_state == S_SCAN)
        else $error("scan pipeline active outside the scan");

    a_full_means_all_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (r_job.op == pht_pkg::CMD_REGISTER) && !r_found)
        |-> (&r_valid))
        else $error("table reported full with an empty entry");

endmodule

`default_nettype wire

[sv/prefix_handler_table_top.sv]
// Top level of the prefix handler table: configuration register, front end and back end.
// Depends on pht_pkg, pht_front, pht_back (and pht_ram below it).
//
//  Channel   Direction  Handshake               Payload
//  command   in         start & !busy           i_command, i_handle, i_prefix_*, i_key_*
//  result    out        o_strobe (one cycle)    o_status, o_hit, o_entry_index,
//                                               o_matched_handle, o_common_bits,
//                                               o_verdict_default
//  config    in         i_cfg_we                i_cfg_wdata (default verdict)
//
// Every command walks all ENTRIES entries of the store, one RAM read per cycle through
// a two-stage compare pipeline; the back end takes the next command only when idle.
// Two further commands can wait in the queue; busy is high while it is full.
// Reset is synchronous and clears the valid bits, the queue and the default verdict.
// The receiver cannot stall: each result appears for exactly one cycle.
`default_nettype none

module prefix_handler_table_top #(
    parameter int ENTRIES = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_command,
    input  wire logic [pht_pkg::HANDLE_W-1:0] i_handle,
    input  wire logic [pht_pkg::HALF_W-1:0]   i_prefix_hi,
    input  wire logic [pht_pkg::HALF_W-1:0]   i_prefix_lo,
    input  wire logic [pht_pkg::LEN_W-1:0]    i_prefix_bits,
    input  wire logic [pht_pkg::HALF_W-1:0]   i_key_hi,
    input  wire logic [pht_pkg::HALF_W-1:0]   i_key_lo,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_wdata,
    output logic                              o_strobe,
    output logic [1:0]                        o_status,
    output logic                              o_hit,
    output logic [2:0]                        o_entry_index,
    output logic [pht_pkg::HANDLE_W-1:0]      o_matched_handle,
    output logic [pht_pkg::CNT_W-1:0]         o_common_bits,
    output logic                              o_verdict_default
);

    logic          r_default_pass;
    pht_pkg::t_req req;
    logic          pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_pass <= 1'b0;
        end else if (i_cfg_we) begin
            r_default_pass <= i_cfg_wdata;
        end
    end

    pht_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_command     (i_command),
        .i_handle      (i_handle),
        .i_prefix_hi   (i_prefix_hi),
        .i_prefix_lo   (i_prefix_lo),
        .i_prefix_bits (i_prefix_bits),
        .i_key_hi      (i_key_hi),
        .i_key_lo      (i_key_lo),
        .o_busy        (busy),
        .o_req         (req),
        .i_pop         (pop)
    );

    pht_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req             (req),
        .o_pop             (pop),
        .i_default_pass    (r_default_pass),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_hit             (o_hit),
        .o_entry_index     (o_entry_index),
        .o_matched_handle  (o_matched_handle),
        .o_common_bits     (o_common_bits),
        .o_verdict_default (o_verdict_default)
    );

endmodule

`default_nettype wire
